// ----- hdl/sgdm_pkg.sv -----
// Package for the SGD momentum weight update block: widths, register codes,
// request and response types, and the fixed-point rounding and saturation helpers.
// Depends on nothing; the top level imports it, while sgdm_ram does not.
package sgdm_pkg;

    // Number formats.
    localparam int FRAC_BITS = 16;
    localparam int WORD_W    = 32;
    localparam int RATE_W    = 24;
    localparam int MOM_W     = 16;
    localparam int IDX_W     = 12;

    // Velocity store geometry (depth is a power of two).
    localparam int VEL_DEPTH = 4096;
    localparam int VEL_AW    = $clog2(VEL_DEPTH);

    // A rate times a word: sign bit + rate bits + word bits.
    localparam int PROD_W = RATE_W + WORD_W + 1;
    localparam int RND_W  = PROD_W + 1;
    localparam int Q_W    = RND_W - FRAC_BITS;

    // Configuration register indexes.
    localparam int CFG_IDX_W = 2;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_STEP_SIZE = 2'd0,
        CFG_MOMENTUM  = 2'd1,
        CFG_DECAY     = 2'd2
    } cfg_reg_t;

    localparam logic [RATE_W-1:0] STEP_SIZE_RESET = RATE_W'(655);

    typedef logic signed [WORD_W-1:0] word_t;
    typedef logic signed [PROD_W-1:0] prod_t;

    localparam word_t WORD_MAX = {1'b0, {(WORD_W-1){1'b1}}};
    localparam word_t WORD_MIN = {1'b1, {(WORD_W-1){1'b0}}};

    localparam logic signed [RND_W-1:0] ROUND_HALF = RND_W'(1) << (FRAC_BITS - 1);

    typedef struct packed {
        logic [IDX_W-1:0]         element_index;
        logic signed [WORD_W-1:0] weight;
        logic signed [WORD_W-1:0] gradient;
    } sgdm_req_t;

    typedef struct packed {
        logic signed [WORD_W-1:0] new_weight;
        logic                     saturated;
    } sgdm_rsp_t;

    typedef struct packed {
        logic  clip;
        word_t value;
    } sat_word_t;

    // Saturates a sum or difference that carries one extra bit.
    function automatic sat_word_t sat_sum(input logic signed [WORD_W:0] s);
        sat_word_t r;
        if (s[WORD_W] == s[WORD_W-1])
        begin
            r.clip  = 1'b0;
            r.value = s[WORD_W-1:0];
        end
        else
        begin
            r.clip  = 1'b1;
            r.value = s[WORD_W] ? WORD_MIN : WORD_MAX;
        end
        return r;
    endfunction

    // Rounds a product half toward plus infinity to FRAC_BITS fraction bits,
    // then saturates it to one word.
    function automatic sat_word_t round_sat(input prod_t p);
        logic signed [RND_W-1:0] pr;
        logic [Q_W-1:0]          q;
        logic [Q_W-WORD_W:0]     top;
        sat_word_t               r;
        pr  = RND_W'(p) + ROUND_HALF;
        q   = pr[RND_W-1:FRAC_BITS];
        top = q[Q_W-1:WORD_W-1];
        if ((&top) || !(|top))
        begin
            r.clip  = 1'b0;
            r.value = q[WORD_W-1:0];
        end
        else
        begin
            r.clip  = 1'b1;
            r.value = q[Q_W-1] ? WORD_MIN : WORD_MAX;
        end
        return r;
    endfunction

endpackage

// ----- hdl/sgdm_ram.sv -----
// Generic single-clock RAM: one write port and one read port with registered read data.
// A read and a write to the same address in one cycle return the old contents.
// No dependencies.
module sgdm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 4096,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- hdl/sgd_momentum_weight_update.sv -----
// Top level of the SGD weight update with momentum and L2 weight decay.
// Depends on sgdm_pkg and on sgdm_ram, which holds the per-element velocity.
//
// A request on the upd channel carries one weight, its gradient and its flat
// element index and is taken at a rising edge where upd_valid is high and
// upd_stall is low. Each request yields one response on the res channel (new
// weight and a saturation flag), in request order, taken at an edge where
// res_valid is high and res_stall is low. The cfg channel writes the step size
// (index 0), momentum (index 1) and the decay factor (index 2); index 3 is
// ignored and cfg_ready is always high. Registers are only to be written while
// no request is in flight.
// The datapath is five registers deep (stages one to four and the output register),
// and one request is accepted every cycle while upd_stall is low, repeated indexes
// included, since velocity updates are forwarded to later reads.
// After reset the velocity RAM is cleared one entry per cycle, all 4096 entries,
// with upd_stall held high; configuration writes are taken meanwhile.
// When the receiver holds res_stall, the pipeline fills behind the output
// register and then raises upd_stall; nothing is dropped or repeated.
module sgd_momentum_weight_update
    import sgdm_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,

    input  logic                 upd_valid,
    output logic                 upd_stall,
    input  sgdm_req_t            upd_req,

    output logic                 res_valid,
    input  logic                 res_stall,
    output sgdm_rsp_t            res_data,

    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [RATE_W-1:0]    cfg_data
);

    // Configuration registers.
    logic [RATE_W-1:0] step_size_reg;
    logic [MOM_W-1:0]  momentum_reg;
    logic [RATE_W-1:0] decay_reg;

    // Velocity clearing sweep after reset.
    logic              clear_reg;
    logic [VEL_AW-1:0] clr_addr_reg;

    // Pipeline valid bits.
    logic s1_valid_reg;
    logic s2_valid_reg;
    logic s3_valid_reg;
    logic s4_valid_reg;
    logic res_valid_reg;

    // Stage payloads.
    logic [VEL_AW-1:0] s1_idx_reg;
    word_t             s1_weight_reg;
    word_t             s1_grad_reg;

    logic [VEL_AW-1:0] s2_idx_reg;
    word_t             s2_weight_reg;
    word_t             s2_grad_reg;
    prod_t             s2_wd_prod_reg;
    word_t             s2_vel_old_reg;

    word_t             s3_weight_reg;
    word_t             s3_operand_reg;
    logic              s3_flag_reg;

    word_t             s4_weight_reg;
    prod_t             s4_lr_prod_reg;
    logic              s4_flag_reg;

    sgdm_rsp_t         res_reg;

    // The two most recent velocity writes, for forwarding.
    logic              wr1_valid_reg;
    logic [VEL_AW-1:0] wr1_idx_reg;
    word_t             wr1_data_reg;
    logic              wr2_valid_reg;
    logic [VEL_AW-1:0] wr2_idx_reg;
    word_t             wr2_data_reg;

    // Handshake and stage movement.
    logic out_free;
    logic s4_free;
    logic s3_free;
    logic s2_free;
    logic s1_free;
    logic accept;

    // Velocity stage signals.
    logic      mom_on;
    sat_word_t wd_term;
    sat_word_t g_sum;
    prod_t     mom_prod;
    sat_word_t mom_term;
    sat_word_t vel_sum;
    word_t     vel_new;
    word_t     s2_operand;
    logic      s2_flag;
    logic      wr_now;
    word_t     vel_old_next;

    // Output stage signals.
    sat_word_t lr_term;
    sat_word_t diff;

    // RAM ports.
    logic              ram_we;
    logic [VEL_AW-1:0] ram_waddr;
    word_t             ram_wdata;
    word_t             ram_rdata;

    // A stage may load when it is empty or its contents move on in this cycle.
    assign out_free  = !res_valid_reg || !res_stall;
    assign s4_free   = !s4_valid_reg || out_free;
    assign s3_free   = !s3_valid_reg || s4_free;
    assign s2_free   = !s2_valid_reg || s3_free;
    assign s1_free   = !s1_valid_reg || s2_free;

    assign upd_stall = clear_reg || !s1_free;
    assign accept    = upd_valid && !upd_stall;
    assign cfg_ready = 1'b1;

    // Configuration writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_size_reg <= STEP_SIZE_RESET;
            momentum_reg  <= '0;
            decay_reg     <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_STEP_SIZE: step_size_reg <= cfg_data;
                CFG_MOMENTUM:  momentum_reg  <= cfg_data[MOM_W-1:0];
                CFG_DECAY:     decay_reg     <= cfg_data;
                default:       ;
            endcase
        end
    end

    // Clearing sweep: one velocity entry per cycle after reset.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clear_reg    <= 1'b1;
            clr_addr_reg <= '0;
        end
        else if (clear_reg)
        begin
            clr_addr_reg <= clr_addr_reg + 1'b1;
            if (clr_addr_reg == VEL_AW'(VEL_DEPTH - 1))
            begin
                clear_reg <= 1'b0;
            end
        end
    end

    // Valid bits advance as each stage frees up.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            s4_valid_reg  <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_free)
            begin
                s1_valid_reg <= accept;
            end
            if (s2_free)
            begin
                s2_valid_reg <= s1_valid_reg;
            end
            if (s3_free)
            begin
                s3_valid_reg <= s2_valid_reg;
            end
            if (s4_free)
            begin
                s4_valid_reg <= s3_valid_reg;
            end
            if (out_free)
            begin
                res_valid_reg <= s4_valid_reg;
            end
        end
    end

    // Velocity RAM. The read is issued as the request is accepted, so the data
    // is ready while the request sits in stage one. No further read can happen
    // before stage one hands the request on.
    assign ram_we    = clear_reg || wr_now;
    assign ram_waddr = clear_reg ? clr_addr_reg : s2_idx_reg;
    assign ram_wdata = clear_reg ? '0 : vel_new;

    sgdm_ram #(
        .WIDTH (WORD_W),
        .DEPTH (VEL_DEPTH)
    ) u_vel_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (accept),
        .raddr (upd_req.element_index[VEL_AW-1:0]),
        .rdata (ram_rdata)
    );

    // Stage one: register the request; the weight decay product is formed here.
    always_ff @(posedge clk)
    begin
        if (s1_free)
        begin
            s1_idx_reg    <= upd_req.element_index[VEL_AW-1:0];
            s1_weight_reg <= upd_req.weight;
            s1_grad_reg   <= upd_req.gradient;
        end
    end

    // The RAM read of the request in stage one can miss up to two writes made
    // after it was issued: the one happening at this edge and the most recent
    // recorded one. A recorded write that predates the read only repeats what
    // the RAM already holds, so the newest match always wins.
    always_comb
    begin
        priority if (wr_now && (s2_idx_reg == s1_idx_reg))
        begin
            vel_old_next = vel_new;
        end
        else if (wr1_valid_reg && (wr1_idx_reg == s1_idx_reg))
        begin
            vel_old_next = wr1_data_reg;
        end
        else if (wr2_valid_reg && (wr2_idx_reg == s1_idx_reg))
        begin
            vel_old_next = wr2_data_reg;
        end
        else
        begin
            vel_old_next = ram_rdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s2_free)
        begin
            s2_idx_reg     <= s1_idx_reg;
            s2_weight_reg  <= s1_weight_reg;
            s2_grad_reg    <= s1_grad_reg;
            s2_wd_prod_reg <= prod_t'($signed({1'b0, decay_reg})) * prod_t'(s1_weight_reg);
            s2_vel_old_reg <= vel_old_next;
        end
    end

    // Stage two: decayed gradient and velocity update.
    assign mom_on   = (momentum_reg != '0);
    assign wd_term  = round_sat(s2_wd_prod_reg);
    assign g_sum    = sat_sum((WORD_W+1)'(s2_grad_reg) + (WORD_W+1)'(wd_term.value));
    assign mom_prod = prod_t'($signed({1'b0, momentum_reg})) * prod_t'(s2_vel_old_reg);
    assign mom_term = round_sat(mom_prod);
    assign vel_sum  = sat_sum((WORD_W+1)'(mom_term.value) + (WORD_W+1)'(g_sum.value));
    assign vel_new  = vel_sum.value;

    // With momentum off the velocity is neither used nor written.
    assign s2_operand = mom_on ? vel_new : g_sum.value;
    assign s2_flag    = wd_term.clip || g_sum.clip || (mom_on && (mom_term.clip || vel_sum.clip));
    assign wr_now     = s2_valid_reg && s3_free && mom_on;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr1_valid_reg <= 1'b0;
            wr2_valid_reg <= 1'b0;
        end
        else if (wr_now)
        begin
            wr1_valid_reg <= 1'b1;
            wr2_valid_reg <= wr1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_now)
        begin
            wr1_idx_reg  <= s2_idx_reg;
            wr1_data_reg <= vel_new;
            wr2_idx_reg  <= wr1_idx_reg;
            wr2_data_reg <= wr1_data_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s3_free)
        begin
            s3_weight_reg  <= s2_weight_reg;
            s3_operand_reg <= s2_operand;
            s3_flag_reg    <= s2_flag;
        end
    end

    // Stage three: learning rate product.
    always_ff @(posedge clk)
    begin
        if (s4_free)
        begin
            s4_weight_reg  <= s3_weight_reg;
            s4_lr_prod_reg <= prod_t'($signed({1'b0, step_size_reg})) * prod_t'(s3_operand_reg);
            s4_flag_reg    <= s3_flag_reg;
        end
    end

    // Stage four: round the step and subtract it from the weight.
    assign lr_term = round_sat(s4_lr_prod_reg);
    assign diff    = sat_sum((WORD_W+1)'(s4_weight_reg) - (WORD_W+1)'(lr_term.value));

    always_ff @(posedge clk)
    begin
        if (out_free)
        begin
            res_reg.new_weight <= diff.value;
            res_reg.saturated  <= s4_flag_reg || lr_term.clip || diff.clip;
        end
    end

    assign res_valid = res_valid_reg;
    assign res_data  = res_reg;

endmodule
